[sv/lagged_fibonacci_range_rng_unit_assert.svh]
// Assertion macros for the lagged Fibonacci range generator.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef LAGGED_FIBONACCI_RANGE_RNG_UNIT_ASSERT_SVH
`define LAGGED_FIBONACCI_RANGE_RNG_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define LFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfr assertion failed");

// Check a condition in the cycle after its trigger.
`define LFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfr assertion failed");

`endif

[sv/lfr_pkg.sv]
// Shared types and constants of the lagged Fibonacci range generator.
// No dependencies; used by the top level.
package lfr_pkg;

    localparam int SHORT_LAG = 24;
    localparam int WORD_W    = 30;
    localparam int DROP_BITS = 6;
    localparam int DRAW_W    = WORD_W - DROP_BITS;

    typedef enum logic [1:0] {
        ACT_SEED  = 2'd0,
        ACT_RANGE = 2'd1,
        ACT_BITS  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SETUP,
        ST_READ,
        ST_ADD,
        ST_CHECK,
        ST_EMIT
    } t_state;

    // Set every bit at and below the top set bit.
    function automatic logic [31:0] smear32(input logic [31:0] v);
        logic [31:0] s;
        s = v;
        for (int i = 0; i < 5; i++) begin
            s = s | (s >> (1 << i));
        end
        return s;
    endfunction

endpackage

[sv/lfr_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module lfr_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 55
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read two words into registers
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

[sv/lagged_fibonacci_range_rng_unit.sv]
// Additive lagged Fibonacci generator (lags 55/24) with range and bit-mask draws.
// Depends on lfr_pkg, lfr_ram and lagged_fibonacci_range_rng_unit_assert.svh.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | input     | i_in_valid / o_in_ready    | action, seed, range low/high, width
//   out     | output    | o_out_valid / i_out_ready  | value, status
//
// Seed: accept, table writes (one word a cycle, the whole table), then emit.
// Range draw: accept, span setup, then tries (each a RAM read, shared add and
// write-back, then compare), then emit; a try is repeated while the masked draw is not
// below the span.
// Bits draw: accept, one try, emit. Unseeded or unused actions: accept, emit.
// Reset clears control state only; the table needs no clearing pass.
// A result waits in the emit state while the output register is full; input is
// taken whenever the sequencer is idle, even with a result still on the output.
module lagged_fibonacci_range_rng_unit #(
    parameter int TABLE_WORDS = 55
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_seed_value,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    input  logic [4:0]         i_bit_width,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic               o_status
);

    `include "lagged_fibonacci_range_rng_unit_assert.svh"

    localparam int IW  = $clog2(TABLE_WORDS);
    localparam int GAP = TABLE_WORDS - lfr_pkg::SHORT_LAG;
    localparam logic [IW-1:0] LAST_IDX    = IW'(TABLE_WORDS - 1);
    localparam logic [IW-1:0] PARTNER_RST = IW'(GAP);
    localparam logic [IW-1:0] WRAP_AT     = IW'(TABLE_WORDS - GAP);

    // Control registers
    lfr_pkg::t_state  r_state, n_state;
    logic [IW-1:0]    r_widx, n_widx;
    logic [IW-1:0]    r_pidx, n_pidx;
    logic             r_seeded, n_seeded;
    logic             r_out_valid, n_out_valid;
    logic [IW-1:0]    r_cnt, n_cnt;

    // Payload registers
    lfr_pkg::t_action                  r_act, n_act;
    logic signed [31:0]                r_lo, n_lo;
    logic signed [31:0]                r_hi, n_hi;
    logic [31:0]                       r_mask, n_mask;
    logic [31:0]                       r_span_m1, n_span_m1;
    logic [lfr_pkg::WORD_W-1:0]        r_f0, n_f0;
    logic [lfr_pkg::WORD_W-1:0]        r_f1, n_f1;
    logic [lfr_pkg::DRAW_W-1:0]        r_k, n_k;
    logic signed [31:0]                r_res_value, n_res_value;
    logic                              r_res_status, n_res_status;
    logic signed [31:0]                r_value, n_value;
    logic                              r_status, n_status;

    // Table RAM and shared adder
    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [lfr_pkg::WORD_W-1:0] ram_wdata;
    logic [lfr_pkg::WORD_W-1:0] ram_rd_a, ram_rd_b;
    logic [lfr_pkg::WORD_W-1:0] w_add_a, w_add_b, w_sum;
    logic signed [32:0]         w_diff;
    logic [IW-1:0]              w_widx_next, w_pidx_next, w_pidx_expect;
    logic [31:0]                w_k_ext;
    logic                       w_slot_free;
    logic                       w_unseeded_draw;

    lfr_ram #(
        .WIDTH(lfr_pkg::WORD_W),
        .DEPTH(TABLE_WORDS)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(r_widx),
        .i_raddr_b(r_pidx),
        .o_rdata_a(ram_rd_a),
        .o_rdata_b(ram_rd_b)
    );

    // Share one 30-bit adder between seeding and drawing
    assign w_add_a = (r_state == lfr_pkg::ST_SEED) ? r_f1 : ram_rd_a;
    assign w_add_b = (r_state == lfr_pkg::ST_SEED) ? r_f0 : ram_rd_b;
    assign w_sum   = w_add_a + w_add_b;

    // Exact span minus one, index advance and the lag relation between indices
    assign w_diff        = {r_hi[31], r_hi} - {r_lo[31], r_lo};
    assign w_widx_next   = (r_widx == LAST_IDX) ? '0 : r_widx + IW'(1);
    assign w_pidx_next   = (r_pidx == LAST_IDX) ? '0 : r_pidx + IW'(1);
    assign w_pidx_expect = (r_widx >= WRAP_AT) ? r_widx - WRAP_AT : r_widx + PARTNER_RST;
    assign w_k_ext       = {{(32 - lfr_pkg::DRAW_W){1'b0}}, r_k};
    assign w_slot_free   = !r_out_valid || i_out_ready;

    // Draw request taken while the table is still unseeded
    assign w_unseeded_draw = o_in_ready && i_in_valid && !r_seeded
                             && (i_action == lfr_pkg::ACT_RANGE
                                 || i_action == lfr_pkg::ACT_BITS);

    assign o_in_ready  = (r_state == lfr_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

    // Sequence next state, table access and result
    always_comb begin
        n_state      = r_state;
        n_widx       = r_widx;
        n_pidx       = r_pidx;
        n_seeded     = r_seeded;
        n_cnt        = r_cnt;
        n_act        = r_act;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mask       = r_mask;
        n_span_m1    = r_span_m1;
        n_f0         = r_f0;
        n_f1         = r_f1;
        n_k          = r_k;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_value      = r_value;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        ram_we       = 1'b0;
        ram_waddr    = r_widx;
        ram_wdata    = w_sum;

        case (r_state)
            lfr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_act        = lfr_pkg::t_action'(i_action);
                    n_lo         = i_range_low;
                    n_hi         = i_range_high;
                    n_mask       = ~(32'hFFFF_FFFF << i_bit_width);
                    n_f1         = i_seed_value[lfr_pkg::WORD_W-1:0];
                    n_cnt        = '0;
                    n_res_value  = '0;
                    n_res_status = 1'b0;
                    case (lfr_pkg::t_action'(i_action))
                        lfr_pkg::ACT_SEED: begin
                            n_state = lfr_pkg::ST_SEED;
                        end
                        lfr_pkg::ACT_RANGE: begin
                            n_state      = r_seeded ? lfr_pkg::ST_SETUP : lfr_pkg::ST_EMIT;
                            n_res_status = !r_seeded;
                        end
                        lfr_pkg::ACT_BITS: begin
                            n_state      = r_seeded ? lfr_pkg::ST_READ : lfr_pkg::ST_EMIT;
                            n_res_status = !r_seeded;
                        end
                        default: begin
                            n_state = lfr_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            lfr_pkg::ST_SEED: begin
                // Write seed, then 1, then running Fibonacci sums
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                if (r_cnt == '0) begin
                    ram_wdata = r_f1;
                end else if (r_cnt == IW'(1)) begin
                    ram_wdata = lfr_pkg::WORD_W'(1);
                end else begin
                    ram_wdata = w_sum;
                end
                n_f0  = r_f1;
                n_f1  = ram_wdata;
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == LAST_IDX) begin
                    n_widx   = '0;
                    n_pidx   = PARTNER_RST;
                    n_seeded = 1'b1;
                    n_state  = lfr_pkg::ST_EMIT;
                end
            end
            lfr_pkg::ST_SETUP: begin
                // Span of at most one returns the low bound without a draw
                if (w_diff[32] || (w_diff == '0)) begin
                    n_res_value = r_lo;
                    n_state     = lfr_pkg::ST_EMIT;
                end else begin
                    n_span_m1 = w_diff[31:0];
                    n_mask    = lfr_pkg::smear32(w_diff[31:0]);
                    n_state   = lfr_pkg::ST_READ;
                end
            end
            lfr_pkg::ST_READ: begin
                n_state = lfr_pkg::ST_ADD;
            end
            lfr_pkg::ST_ADD: begin
                // Store the sum back, advance both indices, mask the draw
                ram_we  = 1'b1;
                n_k     = w_sum[lfr_pkg::WORD_W-1:lfr_pkg::DROP_BITS]
                          & r_mask[lfr_pkg::DRAW_W-1:0];
                n_widx  = w_widx_next;
                n_pidx  = w_pidx_next;
                n_state = lfr_pkg::ST_CHECK;
            end
            lfr_pkg::ST_CHECK: begin
                if (r_act == lfr_pkg::ACT_BITS) begin
                    n_res_value = $signed(w_k_ext);
                    n_state     = lfr_pkg::ST_EMIT;
                end else if (w_k_ext <= r_span_m1) begin
                    n_res_value = r_lo + $signed(w_k_ext);
                    n_state     = lfr_pkg::ST_EMIT;
                end else begin
                    n_state = lfr_pkg::ST_READ;
                end
            end
            lfr_pkg::ST_EMIT: begin
                // Hold the result until the output register is free
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_value     = r_res_value;
                    n_status    = r_res_status;
                    n_state     = lfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfr_pkg::ST_IDLE;
            r_widx      <= '0;
            r_pidx      <= PARTNER_RST;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_pidx      <= n_pidx;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mask       <= n_mask;
        r_span_m1    <= n_span_m1;
        r_f0         <= n_f0;
        r_f1         <= n_f1;
        r_k          <= n_k;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_value      <= n_value;
        r_status     <= n_status;
    end

    `LFR_ASSERT_SAME(a_pidx_lag, 1'b1, r_pidx == w_pidx_expect)
    `LFR_ASSERT_SAME(a_write_unseeded, ram_we && !r_seeded, r_state == lfr_pkg::ST_SEED)
    `LFR_ASSERT_NEXT(a_unseeded_status, w_unseeded_draw, r_state == lfr_pkg::ST_EMIT && r_res_status)
    `LFR_ASSERT_SAME(a_status_value, r_out_valid && r_status, r_value == '0)

endmodule
